// File: hdl/rrcb_pkg.sv
// rrcb_pkg: shared types, constants and tables for the rotated rectangle unit
// no dependencies
package rrcb_pkg;

   localparam int CordicStagesDefault = 16;
   localparam int TurnUnits = 23040;
   localparam int CoordW = 24;
   localparam int SizeW = 23;
   localparam int AngleW = 16;
   localparam int CordW = 34;
   localparam int OfsW = 25;
   localparam int ProdW = 60;
   localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
   localparam int ReqDataW = 160;
   localparam int RspDataW = 288;

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct packed {
      coord_type corner_x;
      coord_type corner_y;
      logic [SizeW-1:0] width;
      logic [SizeW-1:0] height;
      coord_type pivot_dx;
      coord_type pivot_dy;
   } geom_type;

   typedef struct packed {
      logic signed [CordW-1:0] x;
      logic signed [CordW-1:0] y;
      logic signed [CordW-1:0] z;
      logic [1:0] quad;
      geom_type geom;
   } stage_type;

   typedef logic [22:0] frac_arr_type [45];

   function automatic frac_arr_type build_frac();
      frac_arr_type t;
      for (int r = 0; r < 45; r++) begin
         t[r] = 23'((longint'(r) <<< 23) / 45);
      end
      return t;
   endfunction

   function automatic logic signed [CordW-1:0] atan_of(input int i);
      logic signed [CordW-1:0] v;
      unique case (i)
         0: v = 34'sh020000000;
         1: v = 34'sh012E4051E;
         2: v = 34'sh009FB385B;
         3: v = 34'sh0051111D4;
         4: v = 34'sh0028B0D43;
         5: v = 34'sh00145D7E1;
         6: v = 34'sh000A2F61E;
         7: v = 34'sh000517C55;
         8: v = 34'sh00028BE53;
         9: v = 34'sh000145F2F;
         10: v = 34'sh0000A2F98;
         11: v = 34'sh0000517CC;
         12: v = 34'sh000028BE6;
         13: v = 34'sh0000145F3;
         14: v = 34'sh00000A2F9;
         15: v = 34'sh00000517C;
         16: v = 34'sh0000028BE;
         17: v = 34'sh00000145F;
         18: v = 34'sh000000A2F;
         19: v = 34'sh000000517;
         20: v = 34'sh00000028B;
         21: v = 34'sh000000145;
         22: v = 34'sh0000000A2;
         23: v = 34'sh000000051;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/rotated_rect_corners_and_bounds_unit.sv
// rotated_rect_corners_and_bounds_unit: rotates a rectangle's corners about a pivot
// and returns them with their bounding box; depends on rrcb_pkg, rrcb_cordic_cell
// pipeline registers in order: angle wrap, cordic seed, cordic cells, quadrant map, products, corners, box and output
// throughput: one item per cycle while the output is not stalled, set by the chain of cordic cells, one per stage
// the whole pipeline holds while an rsp item waits and rsp_tready is low
// reset clears the valid bits only
module rotated_rect_corners_and_bounds_unit #(
   parameter int CORDIC_STAGES = rrcb_pkg::CordicStagesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // corner_x, corner_y, width, height, pivot_dx, pivot_dy, turn_angle, zero fill
   input  logic [rrcb_pkg::ReqDataW-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // corner1_x, corner1_y .. corner4_x, corner4_y, box_min_x, box_min_y,
   // box_max_x, box_max_y
   output logic [rrcb_pkg::RspDataW-1:0] rsp_tdata
);
   import rrcb_pkg::*;

   localparam frac_arr_type FracTbl = build_frac();

   function automatic coord_type place(input logic signed [OfsW-1:0] ofs,
                                      input logic signed [ProdW:0] sum);
      logic signed [ProdW+1:0] r;
      r = (ProdW+2)'(ofs) + ((ProdW+2)'(sum) + (ProdW+2)'(64'sd536870912) >>> 30);
      if (r > (ProdW+2)'(64'sd8388607)) return 24'sh7FFFFF;
      if (r < -(ProdW+2)'(64'sd8388608)) return 24'sh800000;
      return r[CoordW-1:0];
   endfunction

   logic enable;
   assign enable = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   geom_type geom_in;
   logic signed [AngleW-1:0] angle_in;
   assign geom_in = '{corner_x: req_tdata[23:0], corner_y: req_tdata[47:24],
                      width: req_tdata[70:48], height: req_tdata[93:71],
                      pivot_dx: req_tdata[117:94], pivot_dy: req_tdata[141:118]};
   assign angle_in = req_tdata[157:142];

   // angle wrap and quotient estimate
   logic signed [AngleW:0] a_wide, a_mod;
   logic [14:0] m_in, m_ff;
   logic [9:0] q_in, q_ff;
   logic [25:0] qm_prod;
   logic v0_ff;
   geom_type g0_ff;

   always_comb begin
      a_wide = (AngleW+1)'(angle_in);
      a_mod = a_wide;
      if (a_wide < 0) begin
         a_mod = a_wide + 17'sd23040;
         if (a_mod < 0) begin
            a_mod = a_mod + 17'sd23040;
         end
      end else if (a_wide >= 17'sd23040) begin
         a_mod = a_wide - 17'sd23040;
      end
      m_in = a_mod[14:0];
      qm_prod = 26'(m_in) * 26'd1457;
      q_in = qm_prod[25:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= req_tvalid;
      end
      if (enable) begin
         m_ff <= m_in;
         q_ff <= q_in;
         g0_ff <= geom_in;
      end
   end

   // binary angle and cordic seed
   logic signed [16:0] rem_c;
   logic [9:0] q_c;
   logic [5:0] r_c;
   logic [31:0] bang_c;
   stage_type seed_in, seed_ff;
   logic v1_ff;

   always_comb begin
      rem_c = 17'(m_ff) - 17'(q_ff) * 17'sd45;
      q_c = q_ff;
      r_c = rem_c[5:0];
      if (rem_c < 0) begin
         q_c = q_ff - 10'd1;
         r_c = 6'(rem_c + 17'sd45);
      end
      bang_c = {q_c[8:0], FracTbl[r_c]};
      seed_in.x = CordicGain;
      seed_in.y = '0;
      seed_in.z = CordW'(bang_c[29:0]);
      seed_in.quad = bang_c[31:30];
      seed_in.geom = g0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= v0_ff;
      end
      if (enable) begin
         seed_ff <= seed_in;
      end
   end

   // chain of cordic cells
   logic      vc [CORDIC_STAGES+1];
   stage_type sc [CORDIC_STAGES+1];
   assign vc[0] = v1_ff;
   assign sc[0] = seed_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      rrcb_cordic_cell #(.STAGE(i)) u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(vc[i]), .stage_in(sc[i]),
         .valid_out(vc[i+1]), .stage_out(sc[i+1])
      );
   end

   // quadrant map and offsets
   stage_type st_c;
   logic signed [CordW-1:0] cs_in, sn_in, cs_ff, sn_ff;
   logic signed [OfsW-1:0] dx0_ff, dx1_ff, dy0_ff, dy1_ff, ox_ff, oy_ff;
   logic v2_ff;
   assign st_c = sc[CORDIC_STAGES];

   always_comb begin
      unique case (st_c.quad)
         2'd0: begin cs_in = st_c.x;  sn_in = st_c.y;  end
         2'd1: begin cs_in = -st_c.y; sn_in = st_c.x;  end
         2'd2: begin cs_in = -st_c.x; sn_in = -st_c.y; end
         default: begin cs_in = st_c.y; sn_in = -st_c.x; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= vc[CORDIC_STAGES];
      end
      if (enable) begin
         cs_ff <= cs_in;
         sn_ff <= sn_in;
         dx0_ff <= -OfsW'(st_c.geom.pivot_dx);
         dy0_ff <= -OfsW'(st_c.geom.pivot_dy);
         dx1_ff <= OfsW'($signed({1'b0, st_c.geom.width})) - OfsW'(st_c.geom.pivot_dx);
         dy1_ff <= OfsW'($signed({1'b0, st_c.geom.height})) - OfsW'(st_c.geom.pivot_dy);
         ox_ff <= OfsW'(st_c.geom.corner_x) + OfsW'(st_c.geom.pivot_dx);
         oy_ff <= OfsW'(st_c.geom.corner_y) + OfsW'(st_c.geom.pivot_dy);
      end
   end

   // products
   logic signed [ProdW-1:0] cdx0_ff, cdx1_ff, sdx0_ff, sdx1_ff;
   logic signed [ProdW-1:0] cdy0_ff, cdy1_ff, sdy0_ff, sdy1_ff;
   logic signed [OfsW-1:0] ox3_ff, oy3_ff;
   logic v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= v2_ff;
      end
      if (enable) begin
         cdx0_ff <= ProdW'(cs_ff) * ProdW'(dx0_ff);
         cdx1_ff <= ProdW'(cs_ff) * ProdW'(dx1_ff);
         sdx0_ff <= ProdW'(sn_ff) * ProdW'(dx0_ff);
         sdx1_ff <= ProdW'(sn_ff) * ProdW'(dx1_ff);
         cdy0_ff <= ProdW'(cs_ff) * ProdW'(dy0_ff);
         cdy1_ff <= ProdW'(cs_ff) * ProdW'(dy1_ff);
         sdy0_ff <= ProdW'(sn_ff) * ProdW'(dy0_ff);
         sdy1_ff <= ProdW'(sn_ff) * ProdW'(dy1_ff);
         ox3_ff <= ox_ff;
         oy3_ff <= oy_ff;
      end
   end

   // corners
   coord_type cx_ff [4];
   coord_type cy_ff [4];
   logic v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (enable) begin
         v4_ff <= v3_ff;
      end
      if (enable) begin
         cx_ff[0] <= place(ox3_ff, (ProdW+1)'(cdx0_ff) - (ProdW+1)'(sdy0_ff));
         cy_ff[0] <= place(oy3_ff, (ProdW+1)'(sdx0_ff) + (ProdW+1)'(cdy0_ff));
         cx_ff[1] <= place(ox3_ff, (ProdW+1)'(cdx1_ff) - (ProdW+1)'(sdy0_ff));
         cy_ff[1] <= place(oy3_ff, (ProdW+1)'(sdx1_ff) + (ProdW+1)'(cdy0_ff));
         cx_ff[2] <= place(ox3_ff, (ProdW+1)'(cdx1_ff) - (ProdW+1)'(sdy1_ff));
         cy_ff[2] <= place(oy3_ff, (ProdW+1)'(sdx1_ff) + (ProdW+1)'(cdy1_ff));
         cx_ff[3] <= place(ox3_ff, (ProdW+1)'(cdx0_ff) - (ProdW+1)'(sdy1_ff));
         cy_ff[3] <= place(oy3_ff, (ProdW+1)'(sdx0_ff) + (ProdW+1)'(cdy1_ff));
      end
   end

   // bounding box and output register
   coord_type mnx_c, mny_c, mxx_c, mxy_c;
   coord_type mnx_ff, mny_ff, mxx_ff, mxy_ff;
   coord_type ox_out_ff [4];
   coord_type oy_out_ff [4];
   logic v5_ff;

   always_comb begin
      mnx_c = cx_ff[0];
      mxx_c = cx_ff[0];
      mny_c = cy_ff[0];
      mxy_c = cy_ff[0];
      for (int k = 1; k < 4; k++) begin
         if (cx_ff[k] < mnx_c) mnx_c = cx_ff[k];
         if (cx_ff[k] > mxx_c) mxx_c = cx_ff[k];
         if (cy_ff[k] < mny_c) mny_c = cy_ff[k];
         if (cy_ff[k] > mxy_c) mxy_c = cy_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (enable) begin
         v5_ff <= v4_ff;
      end
      if (enable) begin
         ox_out_ff <= cx_ff;
         oy_out_ff <= cy_ff;
         mnx_ff <= mnx_c;
         mny_ff <= mny_c;
         mxx_ff <= mxx_c;
         mxy_ff <= mxy_c;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata = {mxy_ff, mxx_ff, mny_ff, mnx_ff,
                       oy_out_ff[3], ox_out_ff[3], oy_out_ff[2], ox_out_ff[2],
                       oy_out_ff[1], ox_out_ff[1], oy_out_ff[0], ox_out_ff[0]};

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");
   a_box_x: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mnx_ff <= mxx_ff && mny_ff <= mxy_ff))
      else $error("bounding box inverted");
   a_box_c: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mnx_ff <= ox_out_ff[0] && ox_out_ff[0] <= mxx_ff))
      else $error("corner outside box");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("valid after reset");
endmodule

// File: hdl/rrcb_cordic_cell.sv
// rrcb_cordic_cell: one registered cordic micro-rotation, carries the item along
// depends on rrcb_pkg
module rrcb_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                valid_in,
   input  rrcb_pkg::stage_type stage_in,
   output logic                valid_out,
   output rrcb_pkg::stage_type stage_out
);
   import rrcb_pkg::*;

   localparam logic signed [CordW-1:0] Atan = atan_of(STAGE);

   logic      valid_ff;
   stage_type stage_ff, stage_in_c;

   always_comb begin
      stage_in_c = stage_in;
      if (!stage_in.z[CordW-1]) begin
         stage_in_c.x = stage_in.x - (stage_in.y >>> STAGE);
         stage_in_c.y = stage_in.y + (stage_in.x >>> STAGE);
         stage_in_c.z = stage_in.z - Atan;
      end else begin
         stage_in_c.x = stage_in.x + (stage_in.y >>> STAGE);
         stage_in_c.y = stage_in.y - (stage_in.x >>> STAGE);
         stage_in_c.z = stage_in.z + Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         stage_ff <= stage_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;
endmodule

// File: dv/rotated_rect_corners_and_bounds_unit_checker.sv
// rotated_rect_corners_and_bounds_unit_checker: watches both streams, predicts each
// rotated rectangle and compares it with the rsp item; depends on rrcb_pkg
module rotated_rect_corners_and_bounds_unit_checker #(
   parameter int CORDIC_STAGES = rrcb_pkg::CordicStagesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [rrcb_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [rrcb_pkg::RspDataW-1:0] rsp_tdata,
   output int                            fail_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rrcb_pkg::*;

   localparam longint CoordHi = 8388607;
   localparam longint CoordLo = -8388608;
   localparam longint GainQ30 = 652032874;

   localparam longint ArcTab [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
   };

   logic [RspDataW-1:0] rect_queue [$];

   function automatic longint clip_coord(input longint v);
      if (v > CoordHi) return CoordHi;
      if (v < CoordLo) return CoordLo;
      return v;
   endfunction

   function automatic void turn_sincos(input longint ang, output longint cs,
                                       output longint sn);
      longint m, x, y, z, nx, ny;
      longint unsigned b;
      logic [1:0] quad;
      m = ang % TurnUnits;
      if (m < 0) m += TurnUnits;
      b = (longint'(m) << 32) / TurnUnits;
      quad = b[31:30];
      z = longint'(b & 64'h3FFFFFFF);
      x = GainQ30;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= ArcTab[i];
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += ArcTab[i];
         end
         x = nx;
         y = ny;
      end
      case (quad)
         2'd0: begin cs = x; sn = y; end
         2'd1: begin cs = -y; sn = x; end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endfunction

   function automatic logic [RspDataW-1:0] predict_rect(input logic [ReqDataW-1:0] d);
      longint x, y, w, h, px, py, ang, cs, sn, dx, dy;
      longint cx [4];
      longint cy [4];
      longint mnx, mny, mxx, mxy;
      logic [RspDataW-1:0] r;
      x = longint'($signed(d[23:0]));
      y = longint'($signed(d[47:24]));
      w = longint'(d[70:48]);
      h = longint'(d[93:71]);
      px = longint'($signed(d[117:94]));
      py = longint'($signed(d[141:118]));
      ang = longint'($signed(d[157:142]));
      turn_sincos(ang, cs, sn);
      for (int k = 0; k < 4; k++) begin
         dx = ((k == 1 || k == 2) ? w : 0) - px;
         dy = ((k >= 2) ? h : 0) - py;
         cx[k] = clip_coord(x + px + ((cs * dx - sn * dy + (64'sd1 << 29)) >>> 30));
         cy[k] = clip_coord(y + py + ((sn * dx + cs * dy + (64'sd1 << 29)) >>> 30));
      end
      mnx = cx[0]; mxx = cx[0]; mny = cy[0]; mxy = cy[0];
      for (int k = 1; k < 4; k++) begin
         if (cx[k] < mnx) mnx = cx[k];
         if (cx[k] > mxx) mxx = cx[k];
         if (cy[k] < mny) mny = cy[k];
         if (cy[k] > mxy) mxy = cy[k];
      end
      for (int k = 0; k < 4; k++) begin
         r[48*k +: 24] = cx[k][23:0];
         r[48*k+24 +: 24] = cy[k][23:0];
      end
      r[192 +: 24] = mnx[23:0];
      r[216 +: 24] = mny[23:0];
      r[240 +: 24] = mxx[23:0];
      r[264 +: 24] = mxy[23:0];
      return r;
   endfunction

   assign pending_count = rect_queue.size();

   always @(posedge clock) begin
      logic [RspDataW-1:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) rect_queue.push_back(predict_rect(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (rect_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected rsp item %h", rsp_tdata);
            end else begin
               want = rect_queue.pop_front();
               for (int f = 0; f < 12; f++) begin
                  if (rsp_tdata[24*f +: 24] !== want[24*f +: 24]) begin
                     fail_count++;
                     if (fail_count <= 10)
                        $display("field %0d mismatch: expected %h got %h", f,
                                 want[24*f +: 24], rsp_tdata[24*f +: 24]);
                  end
               end
            end
         end
      end
   end

endmodule

// File: dv/rotated_rect_corners_and_bounds_unit_tb.sv
// rotated_rect_corners_and_bounds_unit_tb: drives rectangles into the unit with
// random idling and back-pressure; depends on rrcb_pkg, the unit and its checker
module rotated_rect_corners_and_bounds_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rrcb_pkg::*;

   localparam int Stages = CordicStagesDefault;
   localparam int IdleLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   int fail_count, pending_count;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 1'b0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rotated_rect_corners_and_bounds_unit #(.CORDIC_STAGES(Stages)) dut (.*);

   rotated_rect_corners_and_bounds_unit_checker #(.CORDIC_STAGES(Stages)) u_checker (.*);

   always @(negedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("rotated_rect_corners_and_bounds_unit verification failed");
         $finish;
      end
   end

   function automatic logic [ReqDataW-1:0] pack_rect(
      input logic [23:0] cx, input logic [23:0] cy, input logic [22:0] w,
      input logic [22:0] h, input logic [23:0] pdx, input logic [23:0] pdy,
      input logic [15:0] ang);
      return {2'b00, ang, pdy, pdx, h, w, cy, cx};
   endfunction

   task automatic send_rect(input logic [ReqDataW-1:0] d);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random(input int n);
      logic [23:0] cx, cy, pdx, pdy;
      logic [22:0] w, h;
      logic [15:0] ang;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0) begin
            cx = 24'($urandom); cy = 24'($urandom); pdx = 24'($urandom);
            pdy = 24'($urandom);
            w = 23'($urandom); h = 23'($urandom);
            ang = 16'($urandom);
         end else begin
            cx = 24'($signed($urandom_range(0, 200000)) - 100000);
            cy = 24'($signed($urandom_range(0, 200000)) - 100000);
            w = 23'($urandom_range(0, 60000));
            h = 23'($urandom_range(0, 60000));
            pdx = 24'($signed($urandom_range(0, 80000)) - 20000);
            pdy = 24'($signed($urandom_range(0, 80000)) - 20000);
            ang = 16'($signed($urandom_range(0, 46080)) - 23040);
         end
         send_rect(pack_rect(cx, cy, w, h, pdx, pdy, ang));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_rect(pack_rect(24'd0, 24'd0, 23'd2560, 23'd1280, 24'd0, 24'd0, 16'd0));
      send_rect(pack_rect(24'd256, 24'd512, 23'd2560, 23'd1280, 24'd1280, 24'd640, 16'd5760));
      send_rect(pack_rect(24'd256, 24'd512, 23'd2560, 23'd1280, 24'd1280, 24'd640, 16'd11520));
      send_rect(pack_rect(24'd256, 24'd512, 23'd2560, 23'd1280, 24'd1280, 24'd640, 16'd17280));
      send_rect(pack_rect(24'd100, 24'd100, 23'd5000, 23'd3000, 24'd0, 24'd0, 16'd23040));
      send_rect(pack_rect(24'd100, 24'd100, 23'd5000, 23'd3000, 24'd0, 24'd0, -16'sd23040));
      send_rect(pack_rect(24'd100, 24'd100, 23'd5000, 23'd3000, 24'd0, 24'd0, -16'sd1));
      send_rect(pack_rect(24'd100, 24'd100, 23'd5000, 23'd3000, 24'd0, 24'd0, 16'd1));
      send_rect(pack_rect(24'd100, 24'd100, 23'd5000, 23'd3000, 24'd0, 24'd0, -16'sd5760));
      send_rect(pack_rect(24'd100, 24'd100, 23'd5000, 23'd3000, 24'd0, 24'd0, 16'd2880));
      send_rect(pack_rect(24'd0, 24'd0, 23'd1000, 23'd1000, 24'hF00000, 24'h100000, 16'd3000));
      send_rect(pack_rect(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 24'd0, 24'd0,
                          16'd0));
      send_rect(pack_rect(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF,
                          24'h7FFFFF, 16'd11520));
      send_rect(pack_rect(24'h800000, 24'h7FFFFF, 23'd0, 23'd0, 24'h800000, 24'h7FFFFF,
                          16'd7000));
      send_rect(pack_rect(24'h7FFFFF, 24'h800000, 23'h7FFFFF, 23'd0, 24'h800000,
                          24'h800000, -16'sd9000));
      send_rect(pack_rect(24'h000000, 24'h000000, 23'd0, 23'h7FFFFF, 24'h7FFFFF,
                          24'h800000, 16'd20000));
      send_rect(pack_rect(24'hFFFFFF, 24'hFFFFFF, 23'd1, 23'd1, 24'hFFFFFF, 24'hFFFFFF,
                          16'd22000));
      send_rect(pack_rect(24'h555555, 24'hAAAAAA, 23'h2AAAAA, 23'h555555, 24'hAAAAAA,
                          24'h555555, 16'h5555));
      send_rect(pack_rect(24'hAAAAAA, 24'h555555, 23'h555555, 23'h2AAAAA, 24'h555555,
                          24'hAAAAAA, 16'hAAAA));

      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         send_random(480);
      join

      send_idle_pct = 80;
      send_random(480);
      send_idle_pct = 0;
      recv_stall_pct = 80;
      send_random(480);
      send_idle_pct = 12;
      recv_stall_pct = 12;
      send_random(490);

      req_tvalid <= 1'b0;
      recv_stall_pct = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (Stages + 10) @(posedge clock);
      if (fail_count == 0) $display("rotated_rect_corners_and_bounds_unit verification clean");
      else $display("rotated_rect_corners_and_bounds_unit verification failed");
      $finish;
   end

endmodule
